@@ src/fdtm_pkg.sv @@
// ----------------------------------------------------------------------------
// fdtm_pkg
// Shared types and constants of the framed date-time message parser.
// ----------------------------------------------------------------------------
package fdtm_pkg;

  localparam int unsigned MaxFieldsDefault  = 16;
  localparam int unsigned FieldCharsDefault = 15;

  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  localparam logic [11:0] AccMax = 12'd4095;

  localparam logic [63:0] TagPatternReset = 64'd17216514554012451;
  localparam logic [3:0]  TagLenReset     = 4'd7;

  localparam logic [0:0] RegTagPattern = 1'd0;
  localparam logic [0:0] RegTagLength  = 1'd1;

  typedef enum logic [1:0] {
    ST_DATE_TIME = 2'd0,
    ST_OTHER_TAG = 2'd1,
    ST_FRAME_ERR = 2'd2,
    ST_VALUE_ERR = 2'd3
  } status_t;

  // Classified beat passed from the front part to the back part.
  typedef struct packed {
    logic       closed;      // frame closed with '>'
    logic       frame_ok;    // no frame error and last visible byte was '>'
    logic       matched;
    logic [4:0] count;
    logic [11:0] v_year;
    logic [11:0] v_month;
    logic [11:0] v_day;
    logic [11:0] v_hour;
    logic [11:0] v_minute;
  } msg_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

endpackage

@@ src/fdtm_front.sv @@
// ----------------------------------------------------------------------------
// fdtm_front
// Byte parser: framing, tag compare and decimal accumulation, one byte per beat.
// ----------------------------------------------------------------------------
module fdtm_front #(
  parameter int unsigned MAX_FIELDS  = 16,
  parameter int unsigned FIELD_CHARS = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               beat,        // input byte accepted
  input  logic [7:0]         data_byte,
  input  logic               end_of_message,
  input  logic [63:0]        tag_pattern,
  input  logic [3:0]         tag_pattern_length,
  output logic               msg_valid,   // a message result is complete this beat
  output fdtm_pkg::msg_t     msg
);
  import fdtm_pkg::*;

  localparam int unsigned FiW = $clog2(MAX_FIELDS + 1);
  localparam int unsigned CiW = $clog2(FIELD_CHARS + 1);

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_FIELDS = 4'b0010,
    PH_CLOSED = 4'b0100,
    PH_ERROR  = 4'b1000
  } phase_t;

  phase_t          phase, phase_next;
  logic [FiW-1:0]  field_index, field_index_next;
  logic [CiW-1:0]  char_in_field, char_in_field_next;
  logic            tag_match, tag_match_next;
  logic            last_gt, last_gt_next;
  logic [11:0]     acc, acc_next;
  logic [1:0]      num_phase, num_phase_next;
  logic            neg, neg_next;
  logic [11:0]     pend [5];
  logic [11:0]     pend_next [5];

  logic [3:0]  plen;
  logic [7:0]  pch;
  logic [3:0]  digit;
  logic        is_digit;
  logic [15:0] acc_mul;
  logic [11:0] fval;
  logic [FiW-1:0] cnt;
  logic        bad_frame;

  assign plen     = (tag_pattern_length > 4'd8) ? 4'd8 : tag_pattern_length;
  assign pch      = tag_pattern[8*char_in_field[2:0] +: 8];
  assign is_digit = (data_byte >= ChZero) && (data_byte <= ChNine);
  assign digit    = 4'(data_byte - ChZero);
  assign acc_mul  = 16'(acc) * 16'd10 + 16'(digit);
  assign fval     = (neg && acc != 12'd0) ? AccMax : acc;

  always_comb begin
    phase_next         = phase;
    field_index_next   = field_index;
    char_in_field_next = char_in_field;
    tag_match_next     = tag_match;
    last_gt_next       = last_gt;
    acc_next           = acc;
    num_phase_next     = num_phase;
    neg_next           = neg;
    for (int i = 0; i < 5; i++) pend_next[i] = pend[i];
    bad_frame          = 1'b0;

    unique case (phase)
      PH_IDLE: begin
        if (data_byte == ChLt) begin
          phase_next = PH_FIELDS;
          field_index_next = '0;
          tag_match_next = 1'b1;
          last_gt_next = 1'b0;
          for (int i = 0; i < 5; i++) pend_next[i] = '0;
          char_in_field_next = '0;
          acc_next = '0;
          num_phase_next = 2'd0;
          neg_next = 1'b0;
        end else if (!is_ws(data_byte)) begin
          phase_next = PH_ERROR;
        end
      end
      PH_FIELDS: begin
        if (!is_ws(data_byte)) last_gt_next = (data_byte == ChGt);
        if (data_byte == ChSemi || data_byte == ChGt) begin
          if (field_index == '0 && (data_byte == ChGt || char_in_field == '0)) begin
            phase_next = PH_ERROR;
          end else begin
            if (field_index < FiW'(MAX_FIELDS)) begin
              if (field_index == '0) begin
                if (char_in_field != CiW'(plen)) tag_match_next = 1'b0;
              end else if (field_index <= FiW'(5)) begin
                pend_next[3'(field_index - FiW'(1))] = fval;
              end
            end
            if (data_byte == ChGt) begin
              phase_next = PH_CLOSED;
            end else if (field_index < FiW'(MAX_FIELDS)) begin
              field_index_next = field_index + FiW'(1);
              char_in_field_next = '0;
              acc_next = '0;
              num_phase_next = 2'd0;
              neg_next = 1'b0;
            end
          end
        end else if (field_index < FiW'(MAX_FIELDS) &&
                     char_in_field < CiW'(FIELD_CHARS)) begin
          char_in_field_next = char_in_field + CiW'(1);
          if (field_index == '0) begin
            if (CiW'(char_in_field) >= CiW'(plen)) tag_match_next = 1'b0;
            else if (pch != ChStar && pch != data_byte) tag_match_next = 1'b0;
          end else if (num_phase == 2'd0) begin
            if (data_byte == ChPlus) begin
              num_phase_next = 2'd1;
            end else if (data_byte == ChMinus) begin
              neg_next = 1'b1;
              num_phase_next = 2'd1;
            end else if (is_digit) begin
              acc_next = 12'(digit);
              num_phase_next = 2'd1;
            end else if (!is_ws(data_byte)) begin
              num_phase_next = 2'd2;
            end
          end else if (num_phase == 2'd1) begin
            if (is_digit) acc_next = (acc_mul > 16'(AccMax)) ? AccMax : acc_mul[11:0];
            else num_phase_next = 2'd2;
          end
        end
      end
      PH_CLOSED: begin
        if (!is_ws(data_byte)) last_gt_next = (data_byte == ChGt);
      end
      PH_ERROR: begin
        bad_frame = 1'b1;
      end
      default: phase_next = PH_ERROR;
    endcase
  end

  // Result is formed from the updated state of this beat.
  assign cnt = (field_index_next < FiW'(MAX_FIELDS)) ? field_index_next + FiW'(1)
                                                     : FiW'(MAX_FIELDS);
  always_comb begin
    msg.closed   = (phase_next == PH_CLOSED);
    msg.frame_ok = (phase_next == PH_CLOSED) && last_gt_next && !bad_frame;
    msg.matched  = tag_match_next;
    msg.count    = (cnt > FiW'(31)) ? 5'd31 : 5'(cnt);
    msg.v_year   = pend_next[0];
    msg.v_month  = pend_next[1];
    msg.v_day    = pend_next[2];
    msg.v_hour   = pend_next[3];
    msg.v_minute = pend_next[4];
  end
  assign msg_valid = beat && end_of_message;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      field_index <= '0;
      char_in_field <= '0;
      tag_match <= 1'b1;
      last_gt <= 1'b0;
      acc <= '0;
      num_phase <= 2'd0;
      neg <= 1'b0;
      for (int i = 0; i < 5; i++) pend[i] <= '0;
    end else if (beat) begin
      for (int i = 0; i < 5; i++) pend[i] <= pend_next[i];
      if (end_of_message) begin
        phase <= PH_IDLE;
        field_index <= '0;
        char_in_field <= '0;
        tag_match <= 1'b1;
        last_gt <= 1'b0;
        acc <= '0;
        num_phase <= 2'd0;
        neg <= 1'b0;
      end else begin
        phase <= phase_next;
        field_index <= field_index_next;
        char_in_field <= char_in_field_next;
        tag_match <= tag_match_next;
        last_gt <= last_gt_next;
        acc <= acc_next;
        num_phase <= num_phase_next;
        neg <= neg_next;
      end
    end
  end

endmodule

@@ src/fdtm_queue.sv @@
// ----------------------------------------------------------------------------
// fdtm_queue
// Two-entry queue of completed messages between parser and result stage.
// ----------------------------------------------------------------------------
module fdtm_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  fdtm_pkg::msg_t wr_data,
  output logic           full,
  output logic           rd_valid,
  input  logic           rd_en,
  output fdtm_pkg::msg_t rd_data
);
  import fdtm_pkg::*;

  msg_t       mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) wr_ptr <= ~wr_ptr;
      if (rd_en) rd_ptr <= ~rd_ptr;
      count <= count + 2'(wr_en) - 2'(rd_en);
    end
  end

endmodule

@@ src/fdtm_back.sv @@
// ----------------------------------------------------------------------------
// fdtm_back
// Range check, stored date-time update and output register.
// ----------------------------------------------------------------------------
module fdtm_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  fdtm_pkg::msg_t msg,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [39:0]    m_axis_tdata
);
  import fdtm_pkg::*;

  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day, hour;
  logic [5:0]  minute;
  logic ok_y, ok_mo, ok_d, ok_h, ok_mi, good, upd;
  status_t st;
  logic [1:0] st_bits;
  logic [11:0] year_n;
  logic [3:0]  month_n;
  logic [4:0]  day_n, hour_n;
  logic [5:0]  minute_n;

  assign in_ready = !m_axis_tvalid || m_axis_tready;
  assign good  = msg.closed && msg.frame_ok;
  assign upd   = in_valid && in_ready && good && msg.matched;
  assign ok_y  = msg.v_year >= 12'd2026 && msg.v_year <= 12'd2999;
  assign ok_mo = msg.v_month >= 12'd1 && msg.v_month <= 12'd12;
  assign ok_d  = msg.v_day >= 12'd1 && msg.v_day <= 12'd31;
  assign ok_h  = msg.v_hour <= 12'd24;
  assign ok_mi = msg.v_minute <= 12'd60;

  always_comb begin
    year_n = year; month_n = month; day_n = day; hour_n = hour; minute_n = minute;
    if (upd) begin
      if (ok_y)  year_n = msg.v_year;
      if (ok_mo) month_n = msg.v_month[3:0];
      if (ok_d)  day_n = msg.v_day[4:0];
      if (ok_h)  hour_n = msg.v_hour[4:0];
      if (ok_mi) minute_n = msg.v_minute[5:0];
    end
    priority if (!good) st = ST_FRAME_ERR;
    else if (!msg.matched) st = ST_OTHER_TAG;
    else if (ok_y && ok_mo && ok_d && ok_h && ok_mi) st = ST_DATE_TIME;
    else st = ST_VALUE_ERR;
  end
  assign st_bits = st;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      year <= '0; month <= '0; day <= '0; hour <= '0; minute <= '0;
    end else begin
      year <= year_n; month <= month_n; day <= day_n; hour <= hour_n;
      minute <= minute_n;
      if (in_ready) m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      m_axis_tdata <= {minute_n, hour_n, day_n, month_n, year_n,
                       good ? msg.count : 5'd0, good && msg.matched, st_bits};
    end
  end

endmodule

@@ src/framed_date_time_message_parser.sv @@
// ----------------------------------------------------------------------------
// framed_date_time_message_parser
// Parses '<tag;year;month;day;hour;minute>' messages and keeps a date-time.
// ----------------------------------------------------------------------------
// One byte is taken per clock. The parser works on each byte in the cycle it
// is accepted; the byte marked end_of_message places a finished message in a
// two-entry queue, and the result stage checks ranges, updates the stored
// date and time and presents the result from its output register. The input
// stalls only when that queue is full.
module framed_date_time_message_parser #(
  parameter int unsigned MAX_FIELDS  = fdtm_pkg::MaxFieldsDefault,
  parameter int unsigned FIELD_CHARS = fdtm_pkg::FieldCharsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tlast,   // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], tag_matched[2], field_count[7:3], year_out[19:8],
  // month_out[23:20], day_out[28:24], hour_out[33:29], minute_out[39:34]
  output logic [39:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);
  import fdtm_pkg::*;

  logic [63:0] tag_pattern;
  logic [3:0]  tag_len;
  logic        beat, msg_valid, q_full, q_valid, q_rd, back_ready;
  msg_t        msg, q_msg;

  assign s_axis_tready = !q_full;
  assign beat = s_axis_tvalid && s_axis_tready;
  assign q_rd = q_valid && back_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_pattern <= TagPatternReset;
      tag_len <= TagLenReset;
    end else if (cfg_we) begin
      if (cfg_index == RegTagPattern) tag_pattern <= cfg_data;
      if (cfg_index == RegTagLength)  tag_len <= cfg_data[3:0];
    end
  end

  fdtm_front #(.MAX_FIELDS(MAX_FIELDS), .FIELD_CHARS(FIELD_CHARS)) u_front (
    .clk, .rst, .beat,
    .data_byte(s_axis_tdata), .end_of_message(s_axis_tlast),
    .tag_pattern, .tag_pattern_length(tag_len),
    .msg_valid, .msg
  );

  fdtm_queue u_queue (
    .clk, .rst, .wr_en(msg_valid), .wr_data(msg), .full(q_full),
    .rd_valid(q_valid), .rd_en(q_rd), .rd_data(q_msg)
  );

  fdtm_back u_back (
    .clk, .rst, .in_valid(q_valid), .in_ready(back_ready), .msg(q_msg),
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

endmodule
